// ===== rtl/dpcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpcm_pkg: shared types and constants
// Request codes, register indexes, the front-to-back beat struct and the
// DPCM step table of the sample voice.
// ----------------------------------------------------------------------------
package dpcm_pkg;

    localparam int unsigned MemBytesDefault = 65536;
    localparam int unsigned MaxStepsDefault = 16;
    localparam int unsigned CfgIdxW         = 3;
    localparam int unsigned CfgDataW        = 28;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_KEYON = 2'd1,
        REQ_KEYOFF = 2'd2,
        REQ_WRITE = 2'd3
    } req_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RATE   = 3'd0,
        CFG_START  = 3'd1,
        CFG_LENGTH = 3'd2,
        CFG_LOOP   = 3'd3,
        CFG_DPCM   = 3'd4,
        CFG_REV    = 3'd5,
        CFG_GAINL  = 3'd6,
        CFG_GAINR  = 3'd7
    } cfg_idx_t;

    // one queued beat from front to back
    typedef struct packed {
        req_t        kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } cmd_t;

    function automatic logic signed [8:0] dpcm_step(input logic [3:0] nib);
        logic signed [8:0] s;
        begin
            case (nib)
                4'd0:  s = 9'sd0;
                4'd1:  s = 9'sd1;
                4'd2:  s = 9'sd2;
                4'd3:  s = 9'sd4;
                4'd4:  s = 9'sd8;
                4'd5:  s = 9'sd16;
                4'd6:  s = 9'sd32;
                4'd7:  s = 9'sd64;
                4'd8:  s = -9'sd128;
                4'd9:  s = -9'sd64;
                4'd10: s = -9'sd32;
                4'd11: s = -9'sd16;
                4'd12: s = -9'sd8;
                4'd13: s = -9'sd4;
                4'd14: s = -9'sd2;
                default: s = -9'sd1;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dpcm_pcm_sample_voice.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpcm_pcm_sample_voice: PCM/DPCM sample playback voice
// Non-tick beats are carried out in the engine's idle state; a tick runs the
// one-carry-per-pass fetch loop, at most MAX_STEPS_PER_TICK carries, through
// the single sample memory read port, and no new beat is taken until it ends.
// A two-beat input queue takes beats while the engine works.
// Reset clears control and sequencer state; sample memory and output registers are undefined.
// ----------------------------------------------------------------------------
module dpcm_pcm_sample_voice #(
    parameter int unsigned MEMORY_BYTES       = dpcm_pkg::MemBytesDefault,
    parameter int unsigned MAX_STEPS_PER_TICK = dpcm_pkg::MaxStepsDefault
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [dpcm_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [dpcm_pkg::CfgDataW-1:0] cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             req_type,
    input  wire logic [15:0]            mem_address,
    input  wire logic [7:0]             mem_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [23:0]          left_sample,
    output logic signed [23:0]          right_sample,
    output logic                        playing
);
    import dpcm_pkg::*;

    logic [27:0] rate_reg;
    logic [15:0] start_reg, len_reg;
    logic        loop_reg, dpcm_reg, rev_reg;
    logic [7:0]  gl_reg, gr_reg;
    cmd_t        in_cmd, q_cmd;
    logic        q_valid, q_pop;

    assign in_cmd.kind = req_t'(req_type);
    assign in_cmd.addr = mem_address;
    assign in_cmd.data = mem_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= 28'd1;
            start_reg <= '0;
            len_reg   <= '0;
            loop_reg  <= 1'b0;
            dpcm_reg  <= 1'b0;
            rev_reg   <= 1'b0;
            gl_reg    <= '0;
            gr_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RATE:   rate_reg  <= cfg_data;
                CFG_START:  start_reg <= cfg_data[15:0];
                CFG_LENGTH: len_reg   <= cfg_data[15:0];
                CFG_LOOP:   loop_reg  <= cfg_data[0];
                CFG_DPCM:   dpcm_reg  <= cfg_data[0];
                CFG_REV:    rev_reg   <= cfg_data[0];
                CFG_GAINL:  gl_reg    <= cfg_data[7:0];
                CFG_GAINR:  gr_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    dpcm_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_cmd,
        .q_valid, .q_pop, .q_cmd
    );

    dpcm_engine #(
        .MEMORY_BYTES(MEMORY_BYTES),
        .MAX_STEPS_PER_TICK(MAX_STEPS_PER_TICK)
    ) u_engine (
        .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
        .rate_step(rate_reg), .start_address(start_reg), .length_bytes(len_reg),
        .loop_enable(loop_reg), .dpcm_mode(dpcm_reg), .reverse_mode(rev_reg),
        .gain_left(gl_reg), .gain_right(gr_reg),
        .out_valid, .out_stall, .left_sample, .right_sample, .playing
    );
endmodule
`default_nettype wire

// ===== rtl/dpcm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpcm_front: input queue
// Takes request beats and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module dpcm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire dpcm_pkg::cmd_t in_cmd,
    output logic               q_valid,
    input  wire logic          q_pop,
    output dpcm_pkg::cmd_t     q_cmd
);
    import dpcm_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != 2'd0) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad count");
endmodule
`default_nettype wire

// ===== rtl/dpcm_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpcm_engine: voice sequencer
// Carries out queued beats: memory writes, key on/off, and ticks that step
// the phase one carry per pass, fetch, decode, interpolate and scale.
// ----------------------------------------------------------------------------
module dpcm_engine #(
    parameter int unsigned MEMORY_BYTES       = dpcm_pkg::MemBytesDefault,
    parameter int unsigned MAX_STEPS_PER_TICK = dpcm_pkg::MaxStepsDefault
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire dpcm_pkg::cmd_t       q_cmd,
    input  wire logic [27:0]          rate_step,
    input  wire logic [15:0]          start_address,
    input  wire logic [15:0]          length_bytes,
    input  wire logic                 loop_enable,
    input  wire logic                 dpcm_mode,
    input  wire logic                 reverse_mode,
    input  wire logic [7:0]           gain_left,
    input  wire logic [7:0]           gain_right,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [23:0]        left_sample,
    output logic signed [23:0]        right_sample,
    output logic                      playing
);
    import dpcm_pkg::*;

    localparam int unsigned AW = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1;
    localparam int unsigned SW = $clog2(MAX_STEPS_PER_TICK + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_STEP  = 8'b00000010,
        S_READ  = 8'b00000100,
        S_DEC   = 8'b00001000,
        S_INTP  = 8'b00010000,
        S_MUL   = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_WAIT  = 8'b10000000
    } state_t;

    state_t state_reg;
    logic [7:0] mem [MEMORY_BYTES];
    logic [7:0] rd_reg;
    logic       rd_oor_reg;
    logic       nib_hi_reg;

    logic [17:0] pos_reg;
    logic [31:0] phase_reg;
    logic signed [7:0] cur_reg, prev_reg;
    logic        active_reg;
    logic [15:0] lstart_reg;
    logic [16:0] lend_reg;
    logic        lloop_reg, ldpcm_reg, lrev_reg;
    logic [SW-1:0] steps_reg;
    logic signed [16:0] iv_reg;
    logic signed [23:0] left_reg, right_reg;
    logic        play_reg, ovalid_reg;

    logic [23:0] rd_addr;
    logic [17:0] pos_next;
    logic        at_end;
    logic signed [13:0] prod62;
    logic signed [9:0]  dval;
    logic signed [7:0]  dec_val;
    logic [3:0]  nib;
    logic signed [8:0]  diff;
    logic signed [17:0] iv_full;
    logic signed [26:0] lmul, rmul;

    assign q_pop = q_valid && (state_reg == S_IDLE) &&
        !(q_cmd.kind == REQ_TICK && ovalid_reg);
    assign out_valid    = ovalid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;
    assign playing      = play_reg;

    // address of the next fetch
    assign pos_next = pos_reg + 18'd1;
    assign at_end   = ({1'b0, pos_next} >= {2'b0, lend_reg});
    always_comb
    begin
        logic [17:0] p;
        p = at_end ? 18'd0 : pos_next;
        if (ldpcm_reg)
        begin
            rd_addr = 24'(lstart_reg) - 24'(lrev_reg) + 24'(p[17:1]);
        end
        else if (lrev_reg)
        begin
            rd_addr = 24'(lstart_reg) - 24'd1 - 24'(p);
        end
        else
        begin
            rd_addr = 24'(lstart_reg) + 24'(p);
        end
    end

    // DPCM decode: floor(v*62/64) + step, clamped; bytes past memory read zero
    assign nib    = rd_oor_reg ? 4'd0 : (nib_hi_reg ? rd_reg[7:4] : rd_reg[3:0]);
    assign prod62 = 14'(cur_reg) * 14'sd62;
    assign dval   = 10'(prod62 >>> 6) + 10'(dpcm_step(nib));
    always_comb
    begin
        if (rd_oor_reg && !ldpcm_reg)
        begin
            dec_val = 8'sd0;
        end
        else if (!ldpcm_reg)
        begin
            dec_val = rd_reg;
        end
        else if (dval > 10'sd127)
        begin
            dec_val = 8'sd127;
        end
        else if (dval < -10'sd128)
        begin
            dec_val = -8'sd128;
        end
        else
        begin
            dec_val = dval[7:0];
        end
    end

    assign diff    = 9'(cur_reg) - 9'(prev_reg);
    assign iv_full = 18'(diff) * $signed({10'd0, phase_reg[23:16]})
                   + (18'(prev_reg) <<< 8);
    assign lmul    = 27'(iv_reg) * $signed({19'd0, gain_left});
    assign rmul    = 27'(iv_reg) * $signed({19'd0, gain_right});

    // sample memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_pop && q_cmd.kind == REQ_WRITE &&
            32'(q_cmd.addr) < MEMORY_BYTES)
        begin
            mem[AW'(q_cmd.addr)] <= q_cmd.data;
        end
        if (state_reg == S_STEP)
        begin
            rd_reg     <= mem[AW'(rd_addr)];
            rd_oor_reg <= (32'(rd_addr) >= MEMORY_BYTES);
            nib_hi_reg <= at_end ? 1'b0 : pos_next[0];
        end
    end

    // datapath registers; an idle tick scales a zero value
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_pop && q_cmd.kind == REQ_TICK && !active_reg)
        begin
            iv_reg <= '0;
        end
        if (state_reg == S_INTP)
        begin
            iv_reg <= 17'(iv_full);
        end
        if (state_reg == S_MUL)
        begin
            left_reg  <= lmul[23:0];
            right_reg <= rmul[23:0];
            play_reg  <= active_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '1;
            phase_reg  <= '1;
            cur_reg    <= '0;
            prev_reg   <= '0;
            active_reg <= 1'b0;
            lstart_reg <= '0;
            lend_reg   <= '0;
            lloop_reg  <= 1'b0;
            ldpcm_reg  <= 1'b0;
            lrev_reg   <= 1'b0;
            steps_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        case (q_cmd.kind)
                            REQ_KEYON:
                            begin
                                lstart_reg <= start_address;
                                ldpcm_reg  <= dpcm_mode;
                                lend_reg   <= dpcm_mode ? {length_bytes, 1'b0}
                                                        : {1'b0, length_bytes};
                                lloop_reg  <= loop_enable;
                                lrev_reg   <= reverse_mode;
                                pos_reg    <= '1;
                                phase_reg  <= '1;
                                cur_reg    <= '0;
                                prev_reg   <= '0;
                                active_reg <= 1'b1;
                            end
                            REQ_KEYOFF: active_reg <= 1'b0;
                            REQ_TICK:
                            begin
                                steps_reg <= '0;
                                if (active_reg)
                                begin
                                    phase_reg <= phase_reg + 32'(rate_step);
                                    state_reg <= S_STEP;
                                end
                                else
                                begin
                                    state_reg <= S_MUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_STEP:
                begin
                    if (phase_reg[31:24] == 8'd0)
                    begin
                        state_reg <= S_INTP;
                    end
                    else if (32'(steps_reg) >= MAX_STEPS_PER_TICK)
                    begin
                        phase_reg[31:24] <= 8'd0;
                        state_reg <= S_INTP;
                    end
                    else
                    begin
                        steps_reg <= steps_reg + SW'(1);
                        phase_reg[31:24] <= phase_reg[31:24] - 8'd1;
                        prev_reg <= cur_reg;
                        if (at_end && !lloop_reg)
                        begin
                            pos_reg    <= pos_next;
                            active_reg <= 1'b0;
                            cur_reg    <= '0;
                            phase_reg[31:24] <= 8'd0;
                            state_reg  <= S_INTP;
                        end
                        else
                        begin
                            pos_reg   <= at_end ? 18'd0 : pos_next;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: state_reg <= S_DEC;
                S_DEC:
                begin
                    cur_reg   <= dec_val;
                    state_reg <= S_STEP;
                end
                S_INTP: state_reg <= S_MUL;
                S_MUL:  state_reg <= S_OUT;
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_steps: assert property (@(posedge clk) disable iff (!rst_n)
        32'(steps_reg) <= MAX_STEPS_PER_TICK) else $error("step overrun");
    a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> !ovalid_reg)
        else $error("output beat overwritten");
    a_idle_play: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> play_reg == active_reg)
        else $error("playing mismatch");
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sample voice playback check
// Drives sample writes, key-on/off and ticks into the voice, predicts every
// tick's stereo output from an in-bench model of the voice and compares each
// output beat in order, under random idling and long receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;
    import dpcm_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          req_type;
    logic [15:0]         mem_address;
    logic [7:0]          mem_byte;
    logic                out_valid;
    logic                out_stall;
    logic signed [23:0]  left_sample;
    logic signed [23:0]  right_sample;
    logic                playing;

    dpcm_pcm_sample_voice u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .mem_address  (mem_address),
        .mem_byte     (mem_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .playing      (playing)
    );

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
        logic        play;
    } voice_out_t;

    // voice model state
    logic [7:0]  vm_mem [0:65535];
    bit          vm_written [0:65535];
    int          vm_pos;
    logic [31:0] vm_phase;
    int          vm_cur;
    int          vm_prev;
    bit          vm_active;
    logic [15:0] lat_start;
    int          lat_end;
    bit          lat_loop, lat_dpcm, lat_rev;
    // live registers
    logic [27:0] r_rate;
    logic [15:0] r_start, r_len;
    bit          r_loop, r_dpcm, r_rev;
    logic [7:0]  r_gl, r_gr;

    voice_out_t  pending_outs[$];
    int          errors;
    int          ticks_sent;
    int          outs_checked;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_recv;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #80ms;
        $display("** dpcm_pcm_sample_voice: FAILED **");
        $finish;
    end

    function automatic int dpcm_delta(input logic [3:0] nib);
        int s;
        case (nib)
            4'd0: s = 0;     4'd1: s = 1;    4'd2: s = 2;    4'd3: s = 4;
            4'd4: s = 8;     4'd5: s = 16;   4'd6: s = 32;   4'd7: s = 64;
            4'd8: s = -128;  4'd9: s = -64;  4'd10: s = -32; 4'd11: s = -16;
            4'd12: s = -8;   4'd13: s = -4;  4'd14: s = -2;  default: s = -1;
        endcase
        return s;
    endfunction

    function automatic int mem_at(input logic [23:0] a);
        if (a >= 24'd65536)
            return 0;
        return int'(vm_mem[a[15:0]]);
    endfunction

    // next sample value at vm_pos
    function automatic int fetch_sample();
        logic [23:0] a;
        int          b;
        int          v;
        logic [3:0]  nib;
        if (lat_dpcm)
        begin
            a = 24'(lat_start) - (lat_rev ? 24'd1 : 24'd0) + 24'(vm_pos >> 1);
            b = mem_at(a);
            nib = (vm_pos & 1) ? b[7:4] : b[3:0];
            v = ((vm_cur * 62) >>> 6) + dpcm_delta(nib);
            if (v > 127) v = 127;
            if (v < -128) v = -128;
            return v;
        end
        a = lat_rev ? 24'(lat_start) - 24'd1 - 24'(vm_pos) : 24'(lat_start) + 24'(vm_pos);
        b = mem_at(a);
        return (b >= 128) ? b - 256 : b;
    endfunction

    // advances the voice by one request; returns 1 when a beat is produced
    function automatic bit voice_request(input req_t kind, input logic [15:0] addr,
                                         input logic [7:0] data, output voice_out_t o);
        int steps;
        int f;
        int iv;
        o = '0;
        case (kind)
            REQ_WRITE:
            begin
                vm_mem[addr] = data;
                vm_written[addr] = 1'b1;
                return 1'b0;
            end
            REQ_KEYON:
            begin
                lat_start = r_start;
                lat_dpcm = r_dpcm;
                lat_end = r_dpcm ? int'(r_len) * 2 : int'(r_len);
                lat_loop = r_loop;
                lat_rev = r_rev;
                vm_pos = -1;
                vm_phase = '1;
                vm_cur = 0;
                vm_prev = 0;
                vm_active = 1'b1;
                return 1'b0;
            end
            REQ_KEYOFF:
            begin
                vm_active = 1'b0;
                return 1'b0;
            end
            default: ;
        endcase
        if (!vm_active)
            return 1'b1;
        vm_phase = vm_phase + 32'(r_rate);
        steps = 0;
        while (vm_phase[31:24] != 0)
        begin
            if (steps >= 16)
            begin
                vm_phase[31:24] = 0;
                break;
            end
            steps++;
            vm_phase = vm_phase - 32'h100_0000;
            vm_pos++;
            vm_prev = vm_cur;
            if (vm_pos >= lat_end)
            begin
                if (lat_loop)
                    vm_pos = 0;
                else
                begin
                    vm_active = 1'b0;
                    vm_cur = 0;
                    vm_phase[31:24] = 0;
                    break;
                end
            end
            vm_cur = fetch_sample();
        end
        f = int'(vm_phase[23:16]);
        iv = (vm_cur - vm_prev) * f + vm_prev * 256;
        o.left = 24'(iv * int'(r_gl));
        o.right = 24'(iv * int'(r_gr));
        o.play = vm_active;
        return 1'b1;
    endfunction

    // samples a voice would read on the next sweep; used to keep reads on written bytes
    function automatic bit span_written(input logic [15:0] st, input logic [15:0] len,
                                        input bit dp, input bit rv);
        logic [23:0] a;
        int n;
        n = (len == 0) ? 1 : int'(len);
        for (int i = 0; i < n; i++)
        begin
            if (dp)
                a = 24'(st) - (rv ? 24'd1 : 24'd0) + 24'(i);
            else
                a = rv ? 24'(st) - 24'd1 - 24'(i) : 24'(st) + 24'(i);
            if (a < 24'd65536 && !vm_written[a[15:0]])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // register write; the caller drops cfg_we after its last write
    task automatic write_reg(input cfg_idx_t idx, input logic [27:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        case (idx)
            CFG_RATE:   r_rate = val;
            CFG_START:  r_start = val[15:0];
            CFG_LENGTH: r_len = val[15:0];
            CFG_LOOP:   r_loop = val[0];
            CFG_DPCM:   r_dpcm = val[0];
            CFG_REV:    r_rev = val[0];
            CFG_GAINL:  r_gl = val[7:0];
            default:    r_gr = val[7:0];
        endcase
    endtask

    // one input beat, driven on the falling edge, accepted at a rising edge
    task automatic send_beat(input req_t kind, input logic [15:0] addr,
                             input logic [7:0] data);
        voice_out_t o;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid    <= 1'b0;
            req_type    <= 2'($urandom);
            mem_address <= 16'($urandom);
            mem_byte    <= 8'($urandom);
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        mem_address <= addr;
        mem_byte    <= data;
        do
            @(posedge clk);
        while (in_stall);
        if (voice_request(kind, addr, data, o))
        begin
            pending_outs.push_back(o);
            ticks_sent++;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_outs.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic fill_bytes(input logic [15:0] base, input int n, input bit rv);
        for (int i = 0; i < n; i++)
            send_beat(REQ_WRITE, rv ? base - 16'(i) - 16'd1 : base + 16'(i), 8'($urandom));
    endtask

    task automatic setup_voice(input logic [27:0] rate, input logic [15:0] st,
                               input logic [15:0] len, input bit lp, input bit dp,
                               input bit rv, input logic [7:0] gl, input logic [7:0] gr);
        wait_drained();
        write_reg(CFG_RATE, rate);
        write_reg(CFG_START, {12'd0, st});
        write_reg(CFG_LENGTH, {12'd0, len});
        write_reg(CFG_LOOP, {27'd0, lp});
        write_reg(CFG_DPCM, {27'd0, dp});
        write_reg(CFG_REV, {27'd0, rv});
        write_reg(CFG_GAINL, {20'd0, gl});
        write_reg(CFG_GAINR, {20'd0, gr});
        cfg_we <= 1'b0;
    endtask

    // output checker
    initial
    begin
        voice_out_t exp_o;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_outs.size() == 0)
                begin
                    $error("output beat with no tick outstanding");
                    errors++;
                end
                else
                begin
                    exp_o = pending_outs.pop_front();
                    outs_checked++;
                    if (left_sample !== exp_o.left)
                    begin
                        $error("left_sample exp %0h got %0h", exp_o.left, left_sample);
                        errors++;
                    end
                    if (right_sample !== exp_o.right)
                    begin
                        $error("right_sample exp %0h got %0h", exp_o.right, right_sample);
                        errors++;
                    end
                    if (playing !== exp_o.play)
                    begin
                        $error("playing exp %0b got %0b", exp_o.play, playing);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stall
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic test_pcm_directed();
        // idle tick before any key-on
        send_beat(REQ_TICK, 16'd0, 8'd0);
        fill_bytes(16'h0000, 8, 1'b0);
        send_beat(REQ_WRITE, 16'h0000, 8'h80);
        send_beat(REQ_WRITE, 16'h0001, 8'h7f);
        send_beat(REQ_WRITE, 16'hffff, 8'hff);
        setup_voice(28'h080_0000, 16'h0000, 16'd8, 1'b0, 1'b0, 1'b0, 8'hff, 8'h00);
        send_beat(REQ_KEYON, 16'h0, 8'h0);
        repeat (20) send_beat(REQ_TICK, 16'($urandom), 8'($urandom));
        // wrap start-1 reverse read at address ffff
        setup_voice(28'hfff_ffff, 16'h0000, 16'd3, 1'b1, 1'b0, 1'b1, 8'h80, 8'hff);
        send_beat(REQ_KEYON, 16'h0, 8'h0);
        fill_bytes(16'h0000, 3, 1'b1);
        repeat (4) send_beat(REQ_TICK, 16'h0, 8'h0);
        send_beat(REQ_KEYOFF, 16'h0, 8'h0);
        send_beat(REQ_TICK, 16'h0, 8'h0);
    endtask

    task automatic test_dpcm_and_edges();
        fill_bytes(16'h0100, 16, 1'b0);
        send_beat(REQ_WRITE, 16'h0100, 8'h77);
        send_beat(REQ_WRITE, 16'h0101, 8'h88);
        setup_voice(28'h100_0000, 16'h0100, 16'd16, 1'b1, 1'b1, 1'b0, 8'h40, 8'hc0);
        send_beat(REQ_KEYON, 16'h0, 8'h0);
        repeat (40) send_beat(REQ_TICK, 16'h0, 8'h0);
        // zero length loop, zero rate
        setup_voice(28'h000_0000, 16'h0100, 16'd0, 1'b1, 1'b0, 1'b0, 8'hff, 8'hff);
        send_beat(REQ_KEYON, 16'h0, 8'h0);
        send_beat(REQ_TICK, 16'h0, 8'h0);
        wait_drained();
        write_reg(CFG_RATE, 28'h300_0000);
        cfg_we <= 1'b0;
        repeat (3) send_beat(REQ_TICK, 16'h0, 8'h0);
    endtask

    task automatic test_random_play(input int n_items);
        int          k;
        logic [15:0] st, len;
        bit          dp, rv;
        k = 0;
        while (k < n_items)
        begin
            len = 16'($urandom_range(1, 40));
            if ($urandom_range(9) == 0) len = 0;
            dp = $urandom_range(1);
            rv = $urandom_range(1);
            st = 16'($urandom_range(64, 65535 - 64));
            if ($urandom_range(7) == 0) st = rv ? 16'h0000 : 16'hffe0;
            if (!span_written(st, len, dp, rv))
            begin
                fill_bytes(dp ? st - 16'(rv) : st, (len == 0) ? 1 : int'(len), rv && !dp);
                k += int'(len);
            end
            setup_voice($urandom_range(7) == 0 ? 28'(($urandom | 1)) :
                        28'($urandom_range(1, 28'h280_0000)),
                        st, len, $urandom_range(1), dp, rv,
                        8'($urandom), 8'($urandom));
            send_beat(REQ_KEYON, 16'($urandom), 8'($urandom));
            for (int i = 0; i < 30; i++)
            begin
                // occasional retrigger or key-off mid-play
                case ($urandom_range(19))
                    0: send_beat(REQ_KEYOFF, 16'($urandom), 8'($urandom));
                    1: send_beat(REQ_KEYON, 16'($urandom), 8'($urandom));
                    default: send_beat(REQ_TICK, 16'($urandom), 8'($urandom));
                endcase
                k++;
            end
        end
    endtask

    task automatic test_backpressure();
        setup_voice(28'h040_0000, 16'h0100, 16'd16, 1'b1, 1'b0, 1'b0, 8'h11, 8'h22);
        send_beat(REQ_KEYON, 16'h0, 8'h0);
        fork
            begin
                hold_recv = 1'b1;
                repeat (400) @(negedge clk);
                hold_recv = 1'b0;
            end
            repeat (12) send_beat(REQ_TICK, 16'h0, 8'h0);
        join
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        ticks_sent = 0;
        outs_checked = 0;
        hold_recv = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_RATE;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_TICK;
        mem_address = '0;
        mem_byte = '0;
        for (int i = 0; i < 65536; i++)
            vm_written[i] = 1'b0;
        vm_pos = -1;
        vm_phase = '1;
        vm_cur = 0;
        vm_prev = 0;
        vm_active = 1'b0;
        lat_start = '0;
        lat_end = 0;
        lat_loop = 0;
        lat_dpcm = 0;
        lat_rev = 0;
        r_rate = 28'd1;
        r_start = '0;
        r_len = '0;
        r_loop = 0;
        r_dpcm = 0;
        r_rev = 0;
        r_gl = '0;
        r_gr = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_pcm_directed();
        test_dpcm_and_edges();
        send_idle_pct = 21;
        recv_idle_pct = 72;
        test_random_play(150);
        send_idle_pct = 72;
        recv_idle_pct = 21;
        test_random_play(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_play(100);
        wait_drained();

        $display("Covered PCM forward/reverse, DPCM, loop/stop, key-on/off and stalls.");
        $display("Ticks sent %0d, output beats checked %0d.", ticks_sent, outs_checked);
        if (errors == 0 && pending_outs.size() == 0)
            $display("** dpcm_pcm_sample_voice: PASSED **");
        else
            $display("** dpcm_pcm_sample_voice: FAILED **");
        $finish;
    end
endmodule
